// ===== hdl/wpsd_pkg.sv =====
// Shared types and constants for the WAV PCM stream decoder.
// Used by wpsd_front, wpsd_queue, wpsd_back and the top level; depends on nothing.
package wpsd_pkg;

  localparam int SEARCH_WINDOW_DEFAULT = 256;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
  localparam logic [15:0] PCM_TAG = 16'h0001;
  localparam int FMT_BASE = 'h14;
  localparam int FMT_END = 'h23;
  localparam logic [23:0] DATA_PREFIX = 24'h64_6174;
  localparam logic [7:0] DATA_LAST = 8'h61;
  localparam logic [7:0] SAMPLE_BIAS = 8'h80;

  typedef enum logic [2:0] {
    KIND_FRAME     = 3'd0,
    KIND_HEADER_OK = 3'd1,
    KIND_NOT_RIFF  = 3'd2,
    KIND_BAD_FMT   = 3'd3,
    KIND_BAD_CHAN  = 3'd4,
    KIND_BAD_BITS  = 3'd5,
    KIND_NO_DATA   = 3'd6,
    KIND_SIZE_ZERO = 3'd7
  } kind_t;

  // One parsed result on its way to the output stage.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;    // rate for header ok, raw frame bytes for a frame
    logic        last;
    logic        stereo;
    logic        wide;    // 16-bit samples
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/wpsd_front.sv =====
// Front end: accepts file bytes, tracks the header parse and assembles frames.
// Pushes one entry per result into the queue. Depends on wpsd_pkg.
module wpsd_front #(
  parameter int SEARCH_WINDOW = wpsd_pkg::SEARCH_WINDOW_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        byte_value,
  input  logic              new_file,
  output logic              push,
  output wpsd_pkg::entry_t  entry
);

  localparam int OFF_W = $clog2(SEARCH_WINDOW);

  typedef enum logic [2:0] {
    PH_WAIT, PH_RIFF, PH_FMT, PH_SEARCH, PH_SIZE, PH_SAMPLES
  } phase_t;

  phase_t             phase, phase_next, cur_phase;
  logic [OFF_W-1:0]   byte_offset, byte_offset_next, cur_off;
  logic [23:0]        marker_window, marker_window_next, cur_marker;
  logic [31:0]        header_word, header_word_next, cur_word, merged;
  logic [15:0]        format_tag, format_tag_next, cur_fmt;
  logic [15:0]        channel_count, channel_count_next, cur_chan;
  logic [15:0]        bits_per_sample, bits_per_sample_next, cur_bits;
  logic [31:0]        rate_value, rate_value_next, cur_rate;
  logic [31:0]        frames_left, frames_left_next, cur_frames, frames_dec;
  logic [1:0]         frame_last, frame_last_next, cur_flast;
  logic [1:0]         byte_in_frame, byte_in_frame_next, cur_bif;
  logic [1:0]         lane;
  logic               stereo, wide;

  function automatic logic [31:0] put_lane(logic [31:0] w, logic [1:0] idx, logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (idx)
      2'd0:    r[7:0]   = b;
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      2'd3:    r[31:24] = b;
      default: r = w;
    endcase
    return r;
  endfunction

  // restart clears everything before the first byte is parsed
  always_comb begin
    if (new_file) begin
      cur_phase  = PH_RIFF;
      cur_off    = '0;
      cur_marker = '0;
      cur_word   = '0;
      cur_fmt    = '0;
      cur_chan   = '0;
      cur_bits   = '0;
      cur_rate   = '0;
      cur_frames = '0;
      cur_flast  = '0;
      cur_bif    = '0;
    end else begin
      cur_phase  = phase;
      cur_off    = byte_offset;
      cur_marker = marker_window;
      cur_word   = header_word;
      cur_fmt    = format_tag;
      cur_chan   = channel_count;
      cur_bits   = bits_per_sample;
      cur_rate   = rate_value;
      cur_frames = frames_left;
      cur_flast  = frame_last;
      cur_bif    = byte_in_frame;
    end
  end

  assign lane       = (cur_phase == PH_RIFF) ? cur_off[1:0] : cur_bif;
  assign merged     = put_lane(cur_word, lane, byte_value);
  assign stereo     = (cur_chan == 16'd2);
  assign wide       = (cur_bits == 16'd16);
  assign frames_dec = cur_frames - 32'd1;

  always_comb begin
    phase_next           = phase;
    byte_offset_next     = byte_offset;
    marker_window_next   = marker_window;
    header_word_next     = header_word;
    format_tag_next      = format_tag;
    channel_count_next   = channel_count;
    bits_per_sample_next = bits_per_sample;
    rate_value_next      = rate_value;
    frames_left_next     = frames_left;
    frame_last_next      = frame_last;
    byte_in_frame_next   = byte_in_frame;
    push                 = 1'b0;
    entry                = '{kind: wpsd_pkg::KIND_FRAME, word: '0, last: 1'b0,
                             stereo: 1'b0, wide: 1'b0};
    if (accept) begin
      phase_next           = cur_phase;
      byte_offset_next     = cur_off;
      marker_window_next   = cur_marker;
      header_word_next     = cur_word;
      format_tag_next      = cur_fmt;
      channel_count_next   = cur_chan;
      bits_per_sample_next = cur_bits;
      rate_value_next      = cur_rate;
      frames_left_next     = cur_frames;
      frame_last_next      = cur_flast;
      byte_in_frame_next   = cur_bif;
      case (cur_phase)
        PH_RIFF: begin
          byte_offset_next = cur_off + OFF_W'(1);
          header_word_next = merged;
          if (cur_off[1:0] == 2'd3) begin
            header_word_next = '0;
            if (merged != wpsd_pkg::RIFF_TAG) begin
              phase_next = PH_WAIT;
              push       = 1'b1;
              entry.kind = wpsd_pkg::KIND_NOT_RIFF;
            end else begin
              phase_next = PH_FMT;
            end
          end
        end
        PH_FMT: begin
          byte_offset_next = cur_off + OFF_W'(1);
          if (cur_off == OFF_W'(wpsd_pkg::FMT_BASE))
            format_tag_next[7:0] = byte_value;
          else if (cur_off == OFF_W'(wpsd_pkg::FMT_BASE + 1))
            format_tag_next[15:8] = byte_value;
          else if (cur_off == OFF_W'(wpsd_pkg::FMT_BASE + 2))
            channel_count_next[7:0] = byte_value;
          else if (cur_off == OFF_W'(wpsd_pkg::FMT_BASE + 3))
            channel_count_next[15:8] = byte_value;
          else if (cur_off >= OFF_W'(wpsd_pkg::FMT_BASE + 4) &&
                   cur_off <= OFF_W'(wpsd_pkg::FMT_BASE + 7))
            rate_value_next = put_lane(cur_rate, cur_off[1:0], byte_value);
          else if (cur_off == OFF_W'(wpsd_pkg::FMT_END - 1))
            bits_per_sample_next[7:0] = byte_value;
          else if (cur_off == OFF_W'(wpsd_pkg::FMT_END))
            bits_per_sample_next[15:8] = byte_value;
          if (cur_off == OFF_W'(wpsd_pkg::FMT_END)) begin
            if (format_tag_next != wpsd_pkg::PCM_TAG) begin
              phase_next = PH_WAIT;
              push       = 1'b1;
              entry.kind = wpsd_pkg::KIND_BAD_FMT;
            end else if (channel_count_next != 16'd1 && channel_count_next != 16'd2) begin
              phase_next = PH_WAIT;
              push       = 1'b1;
              entry.kind = wpsd_pkg::KIND_BAD_CHAN;
            end else if (bits_per_sample_next != 16'd8 &&
                         bits_per_sample_next != 16'd16) begin
              phase_next = PH_WAIT;
              push       = 1'b1;
              entry.kind = wpsd_pkg::KIND_BAD_BITS;
            end else begin
              marker_window_next = '0;
              phase_next         = PH_SEARCH;
            end
          end
        end
        PH_SEARCH: begin
          if (cur_marker == wpsd_pkg::DATA_PREFIX && byte_value == wpsd_pkg::DATA_LAST) begin
            phase_next         = PH_SIZE;
            header_word_next   = '0;
            byte_in_frame_next = '0;
          end else begin
            marker_window_next = {cur_marker[15:0], byte_value};
            if (cur_off >= OFF_W'(SEARCH_WINDOW - 1)) begin
              phase_next = PH_WAIT;
              push       = 1'b1;
              entry.kind = wpsd_pkg::KIND_NO_DATA;
            end else begin
              byte_offset_next = cur_off + OFF_W'(1);
            end
          end
        end
        PH_SIZE: begin
          header_word_next = merged;
          if (cur_bif != 2'd3) begin
            byte_in_frame_next = cur_bif + 2'd1;
          end else begin
            byte_in_frame_next = '0;
            push               = 1'b1;
            if (merged == '0) begin
              phase_next = PH_WAIT;
              entry.kind = wpsd_pkg::KIND_SIZE_ZERO;
            end else begin
              // frame size is 1, 2 or 4 bytes: divide the size by a shift
              frame_last_next = {stereo & wide, stereo | wide};
              if (stereo && wide)
                frames_left_next = {2'b00, merged[31:2]};
              else if (stereo || wide)
                frames_left_next = {1'b0, merged[31:1]};
              else
                frames_left_next = merged;
              header_word_next = '0;
              phase_next       = (frames_left_next == '0) ? PH_WAIT : PH_SAMPLES;
              entry.kind       = wpsd_pkg::KIND_HEADER_OK;
              entry.word       = cur_rate;
              entry.stereo     = stereo;
              entry.wide       = wide;
            end
          end
        end
        PH_SAMPLES: begin
          if (cur_bif != cur_flast) begin
            header_word_next   = merged;
            byte_in_frame_next = cur_bif + 2'd1;
          end else begin
            header_word_next   = '0;
            byte_in_frame_next = '0;
            frames_left_next   = frames_dec;
            if (frames_dec == '0)
              phase_next = PH_WAIT;
            push         = 1'b1;
            entry.kind   = wpsd_pkg::KIND_FRAME;
            entry.word   = merged;
            entry.last   = (frames_dec == '0);
            entry.stereo = stereo;
            entry.wide   = wide;
          end
        end
        default: begin
          phase_next = cur_phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      byte_offset     <= '0;
      marker_window   <= '0;
      header_word     <= '0;
      format_tag      <= '0;
      channel_count   <= '0;
      bits_per_sample <= '0;
      rate_value      <= '0;
      frames_left     <= '0;
      frame_last      <= '0;
      byte_in_frame   <= '0;
    end else begin
      phase           <= phase_next;
      byte_offset     <= byte_offset_next;
      marker_window   <= marker_window_next;
      header_word     <= header_word_next;
      format_tag      <= format_tag_next;
      channel_count   <= channel_count_next;
      bits_per_sample <= bits_per_sample_next;
      rate_value      <= rate_value_next;
      frames_left     <= frames_left_next;
      frame_last      <= frame_last_next;
      byte_in_frame   <= byte_in_frame_next;
    end
  end

endmodule

// ===== hdl/wpsd_queue.sv =====
// Short result queue between the parsing front end and the output stage.
// Depends on wpsd_pkg for the entry type and depth.
module wpsd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wpsd_pkg::entry_t     push_entry,
  input  logic                 pop,
  output wpsd_pkg::entry_t     head,
  output wpsd_pkg::q_status_t  status
);

  localparam int DEPTH = wpsd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wpsd_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push)
      slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)
        count <= count + CNT_W'(1);
      else if (pop && !push)
        count <= count - CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !status.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue pop while empty");
`endif

endmodule

// ===== hdl/wpsd_back.sv =====
// Output stage: pops queue entries, converts frame bytes to signed samples
// and holds the result register toward the consumer. Depends on wpsd_pkg.
module wpsd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  wpsd_pkg::entry_t     head,
  input  wpsd_pkg::q_status_t  status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           kind,
  output logic signed [15:0]   left_sample,
  output logic signed [15:0]   right_sample,
  output logic                 last_frame,
  output logic [31:0]          sample_rate,
  output logic                 two_channels,
  output logic                 sixteen_bit
);

  logic        is_frame, is_header;
  logic [15:0] left_conv, right_conv;

  assign pop       = !status.empty && (!out_valid || !out_stall);
  assign is_frame  = (head.kind == wpsd_pkg::KIND_FRAME);
  assign is_header = (head.kind == wpsd_pkg::KIND_HEADER_OK);

  // 8-bit samples are unsigned: flip the top bit and move to the high byte
  always_comb begin
    if (head.wide) begin
      left_conv  = head.word[15:0];
      right_conv = head.stereo ? head.word[31:16] : head.word[15:0];
    end else begin
      left_conv  = {head.word[7:0] ^ wpsd_pkg::SAMPLE_BIAS, 8'h00};
      right_conv = head.stereo ? {head.word[15:8] ^ wpsd_pkg::SAMPLE_BIAS, 8'h00} : left_conv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind         <= head.kind;
      left_sample  <= is_frame ? left_conv : 16'sd0;
      right_sample <= is_frame ? right_conv : 16'sd0;
      last_frame   <= is_frame & head.last;
      sample_rate  <= is_header ? head.word : 32'd0;
      two_channels <= is_header & head.stereo;
      sixteen_bit  <= is_header & head.wide;
    end
  end

`ifndef SYNTHESIS
  a_frame_no_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == wpsd_pkg::KIND_FRAME |->
      sample_rate == 32'd0 && !two_channels && !sixteen_bit)
    else $error("frame result carries header fields");
  a_nonframe_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != wpsd_pkg::KIND_FRAME |->
      left_sample == 16'sd0 && right_sample == 16'sd0 && !last_frame)
    else $error("non-frame result carries samples");
`endif

endmodule

// ===== hdl/wav_pcm_stream_decoder_top.sv =====
// Top level of the WAV PCM stream decoder: front parser, result queue, output stage.
// Depends on wpsd_pkg, wpsd_front, wpsd_queue and wpsd_back.

// Feed a RIFF/WAVE file one byte per item, with new_file high on the first
// byte; that restarts parsing from any point. The block checks the RIFF tag,
// reads the PCM format fields at offset 0x14, searches for the data marker up
// to SEARCH_WINDOW bytes into the file and then gives one header-ok result
// (rate, stereo, 16-bit) followed by one stereo frame per sample frame, mono
// copied to both channels and 8-bit samples re-centered to signed 16 bit.
// Any failure gives one coded result and the block ignores bytes until the
// next new_file. Rate: one byte per clock while the queue has room; every step
// is a small register update in the front parser. A result passes through the
// queue and then the output register. A four-entry queue separates the parser
// from the output register, so the input stalls only once five results wait:
// four in the queue and one held in the output register.
// No clearing pass after reset.
module wav_pcm_stream_decoder_top #(
  parameter int SEARCH_WINDOW = wpsd_pkg::SEARCH_WINDOW_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         byte_value,
  input  logic               new_file,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         kind,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic               last_frame,
  output logic [31:0]        sample_rate,
  output logic               two_channels,
  output logic               sixteen_bit
);

  wpsd_pkg::entry_t    push_entry, head;
  wpsd_pkg::q_status_t q_status;
  logic                accept, push, pop;

  // hold the byte source off only when the queue has no room
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  wpsd_front #(
    .SEARCH_WINDOW(SEARCH_WINDOW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (byte_value),
    .new_file   (new_file),
    .push       (push),
    .entry      (push_entry)
  );

  wpsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  wpsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .status       (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_frame   (last_frame),
    .sample_rate  (sample_rate),
    .two_channels (two_channels),
    .sixteen_bit  (sixteen_bit)
  );

endmodule

// ===== sim/wav_decode_checker.sv =====
// Watches both channels of the WAV PCM stream decoder, predicts each result from
// the accepted bytes and compares it with what the block hands out. Depends on wpsd_pkg.
module wav_decode_checker #(
  parameter int SEARCH_WINDOW = wpsd_pkg::SEARCH_WINDOW_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        new_file,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  kind,
  input  logic [15:0] left_sample,
  input  logic [15:0] right_sample,
  input  logic        last_frame,
  input  logic [31:0] sample_rate,
  input  logic        two_channels,
  input  logic        sixteen_bit,
  input  logic        closing,
  output int          due_count,
  output int          error_count
);

  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_TAG,
    PARSE_FORMAT,
    PARSE_SEARCH,
    PARSE_SIZE,
    PARSE_FRAMES
  } parse_phase_t;

  typedef struct packed {
    wpsd_pkg::kind_t kind;
    logic [15:0]     left_val;
    logic [15:0]     right_val;
    logic            last_flag;
    logic [31:0]     rate;
    logic            stereo;
    logic            wide;
  } wav_result_t;

  parse_phase_t phase;
  logic [8:0]   byte_off;
  logic [23:0]  mark_win;
  logic [31:0]  hdr_word;
  logic [15:0]  fmt_tag;
  logic [15:0]  chans;
  logic [15:0]  sample_bits;
  logic [31:0]  rate_val;
  logic [31:0]  frames_left;
  logic [23:0]  frame_len;
  logic [1:0]   byte_in_frame;

  wav_result_t due_results[$];
  wav_result_t next_res;
  wav_result_t oldest;
  int          mismatch_total = 0;
  bit          closed = 1'b0;

  function automatic void restart_parse();
    phase = PARSE_IDLE;
    byte_off = '0;
    mark_win = '0;
    hdr_word = '0;
    fmt_tag = '0;
    chans = '0;
    sample_bits = '0;
    rate_val = '0;
    frames_left = '0;
    frame_len = '0;
    byte_in_frame = '0;
  endfunction

  function automatic bit give_up(output wav_result_t res, input wpsd_pkg::kind_t code);
    phase = PARSE_IDLE;
    res = '0;
    res.kind = code;
    return 1'b1;
  endfunction

  // Advance the parser by one byte; return 1 when the byte completes a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic nf,
                                     output wav_result_t res);
    logic [31:0] b32;
    logic [8:0]  off;
    logic [15:0] lv;
    logic [15:0] rv;
    int          fb_calc;
    b32 = {24'd0, b};
    res = '0;
    if (nf) begin
      restart_parse();
      phase = PARSE_TAG;
    end
    case (phase)
      PARSE_TAG: begin
        hdr_word = hdr_word | (b32 << (8 * byte_off[1:0]));
        if (byte_off < 3) begin
          byte_off = byte_off + 1;
          return 1'b0;
        end
        byte_off = byte_off + 1;
        if (hdr_word != wpsd_pkg::RIFF_TAG) return give_up(res, wpsd_pkg::KIND_NOT_RIFF);
        hdr_word = '0;
        phase = PARSE_FORMAT;
        return 1'b0;
      end
      PARSE_FORMAT: begin
        off = byte_off;
        if (off == 'h14 || off == 'h15)
          fmt_tag = fmt_tag | (b32[15:0] << (8 * (off - 'h14)));
        else if (off == 'h16 || off == 'h17)
          chans = chans | (b32[15:0] << (8 * (off - 'h16)));
        else if (off >= 'h18 && off <= 'h1b)
          rate_val = rate_val | (b32 << (8 * (off - 'h18)));
        else if (off == 'h22 || off == 'h23)
          sample_bits = sample_bits | (b32[15:0] << (8 * (off - 'h22)));
        byte_off = byte_off + 1;
        if (off == wpsd_pkg::FMT_END) begin
          if (fmt_tag != wpsd_pkg::PCM_TAG) return give_up(res, wpsd_pkg::KIND_BAD_FMT);
          if (chans != 1 && chans != 2) return give_up(res, wpsd_pkg::KIND_BAD_CHAN);
          if (sample_bits != 8 && sample_bits != 16)
            return give_up(res, wpsd_pkg::KIND_BAD_BITS);
          mark_win = '0;
          phase = PARSE_SEARCH;
        end
        return 1'b0;
      end
      PARSE_SEARCH: begin
        if (mark_win == wpsd_pkg::DATA_PREFIX && b == wpsd_pkg::DATA_LAST) begin
          phase = PARSE_SIZE;
          hdr_word = '0;
          byte_in_frame = '0;
          return 1'b0;
        end
        mark_win = {mark_win[15:0], b};
        if (byte_off >= SEARCH_WINDOW - 1) return give_up(res, wpsd_pkg::KIND_NO_DATA);
        byte_off = byte_off + 1;
        return 1'b0;
      end
      PARSE_SIZE: begin
        hdr_word = hdr_word | (b32 << (8 * byte_in_frame));
        if (byte_in_frame < 3) begin
          byte_in_frame = byte_in_frame + 1;
          return 1'b0;
        end
        byte_in_frame = '0;
        if (hdr_word == 0) return give_up(res, wpsd_pkg::KIND_SIZE_ZERO);
        fb_calc = int'(chans) * int'(sample_bits) / 8;
        if (fb_calc < 1 || fb_calc > 4) fb_calc = 1;
        frame_len = fb_calc[23:0];
        frames_left = hdr_word / {8'd0, frame_len};
        hdr_word = '0;
        phase = (frames_left == 0) ? PARSE_IDLE : PARSE_FRAMES;
        res.kind = wpsd_pkg::KIND_HEADER_OK;
        res.rate = rate_val;
        res.stereo = (chans == 2);
        res.wide = (sample_bits == 16);
        return 1'b1;
      end
      PARSE_FRAMES: begin
        hdr_word = hdr_word | (b32 << (8 * byte_in_frame));
        if (int'(byte_in_frame) + 1 < int'(frame_len)) begin
          byte_in_frame = byte_in_frame + 1;
          return 1'b0;
        end
        // 8-bit samples are unsigned: flip the top bit and move to the high byte
        if (sample_bits == 8) begin
          lv = {hdr_word[7:0] ^ wpsd_pkg::SAMPLE_BIAS, 8'h00};
          rv = (chans == 2) ? {hdr_word[15:8] ^ wpsd_pkg::SAMPLE_BIAS, 8'h00} : lv;
        end else begin
          lv = hdr_word[15:0];
          rv = (chans == 2) ? hdr_word[31:16] : lv;
        end
        hdr_word = '0;
        byte_in_frame = '0;
        frames_left = frames_left - 1;
        res.kind = wpsd_pkg::KIND_FRAME;
        res.left_val = lv;
        res.right_val = rv;
        res.last_flag = (frames_left == 0);
        if (frames_left == 0) phase = PARSE_IDLE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("checker: mismatch at %0t: %s", $realtime, msg);
    mismatch_total++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      due_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (decode_byte(byte_value, new_file, next_res)) due_results.push_back(next_res);
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result of kind %0d with nothing due", kind));
        end else begin
          oldest = due_results.pop_front();
          if (kind !== oldest.kind || left_sample !== oldest.left_val ||
              right_sample !== oldest.right_val || last_frame !== oldest.last_flag ||
              sample_rate !== oldest.rate || two_channels !== oldest.stereo ||
              sixteen_bit !== oldest.wide)
            report_mismatch($sformatf(
              "got kind %0d L %h R %h last %b rate %h st %b w %b, want %0d %h %h %b %h %b %b",
              kind, left_sample, right_sample, last_frame, sample_rate, two_channels,
              sixteen_bit, oldest.kind, oldest.left_val, oldest.right_val,
              oldest.last_flag, oldest.rate, oldest.stereo, oldest.wide));
        end
      end
      if (closing && !closed) begin
        closed <= 1'b1;
        if (due_results.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", due_results.size()));
      end
    end
    due_count <= due_results.size();
    error_count <= mismatch_total;
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the WAV PCM stream decoder testbench: clock, reset, WAV file stimulus,
// random idling on both channels, watchdog and verdict. Depends on wpsd_pkg,
// wav_pcm_stream_decoder_top and wav_decode_checker.
module testbench;

  // Stop the run if nothing moves on either channel for this many cycles.
  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  byte_value = 8'd0;
  logic        new_file = 1'b0;
  logic        out_stall = 1'b0;
  logic        calm = 1'b0;      // high: no idling on either side
  logic        closing = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire  [2:0]  kind;
  wire  signed [15:0] left_sample;
  wire  signed [15:0] right_sample;
  wire         last_frame;
  wire  [31:0] sample_rate;
  wire         two_channels;
  wire         sixteen_bit;
  int          due_count;
  int          error_count;
  int          quiet_cycles = 0;
  int          fed_bytes = 0;
  logic [7:0]  file_bytes[$];   // the file being built, offset 0 first

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wav_pcm_stream_decoder_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .byte_value(byte_value), .new_file(new_file),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .left_sample(left_sample), .right_sample(right_sample),
    .last_frame(last_frame), .sample_rate(sample_rate),
    .two_channels(two_channels), .sixteen_bit(sixteen_bit)
  );

  wav_decode_checker result_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .byte_value(byte_value), .new_file(new_file),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .left_sample(left_sample), .right_sample(right_sample),
    .last_frame(last_frame), .sample_rate(sample_rate),
    .two_channels(two_channels), .sixteen_bit(sixteen_bit),
    .closing(closing), .due_count(due_count), .error_count(error_count)
  );

  // Hold off the consumer at random, about 23 percent of the time, except while calm.
  always @(posedge clk)
    out_stall <= !calm && ($urandom_range(99) < 23);

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Offer one byte, idling at random first; hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic nf);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_value <= b;
    new_file <= nf;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fed_bytes++;
  endtask

  // Stream the built file, new_file on its first byte only.
  task automatic feed_file();
    int i;
    for (i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == 0);
  endtask

  // Loose bytes with no new_file: dropped while the parser waits.
  task automatic send_noise(input int n);
    int i;
    for (i = 0; i < n; i++) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic push_le(input logic [31:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic push_random(input int n);
    int i;
    for (i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic trim_file(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  // Lay down offsets 0 .. 0x23: RIFF tag, WAVE, fmt chunk with the given fields.
  task automatic build_header(input logic [15:0] fmt_code, input logic [15:0] chans,
                              input logic [15:0] sample_bits, input logic [31:0] rate);
    file_bytes.delete();
    push_le(wpsd_pkg::RIFF_TAG, 4);
    push_random(4);
    push_le(32'h4556_4157, 4);
    push_le(32'h2074_6d66, 4);
    push_le(32'd16, 4);
    push_le(32'(fmt_code), 2);
    push_le(32'(chans), 2);
    push_le(rate, 4);
    push_random(6);          // byte rate and block align are not parsed
    push_le(32'(sample_bits), 2);
  endtask

  // Append filler, the data marker, its size word and random sample bytes.
  task automatic append_data(input int gap, input logic [31:0] data_len, input int body);
    push_random(gap);
    push_le(32'h6174_6164, 4);
    push_le(data_len, 4);
    push_random(body);
  endtask

  initial begin
    int          pick;
    int          gap;
    int          nfr;
    int          body;
    int          fb;
    int          file_no;
    int          flaw;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [15:0] sample_bits;
    logic [31:0] rate;
    logic [31:0] data_len;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed files ---
    // Bytes before any file are dropped.
    send_noise(3);
    // Mono 8-bit, extreme sample bytes, zero rate.
    build_header(wpsd_pkg::PCM_TAG, 16'd1, 16'd8, 32'd0);
    append_data(0, 32'd4, 0);
    push_le(32'h7f80_ff00, 4);
    feed_file();
    // Stereo 8-bit, top rate.
    build_header(wpsd_pkg::PCM_TAG, 16'd2, 16'd8, 32'hffff_ffff);
    append_data(1, 32'd4, 0);
    push_le(32'h807f_ff00, 4);
    feed_file();
    // Mono 16-bit, most negative and most positive samples.
    build_header(wpsd_pkg::PCM_TAG, 16'd1, 16'd16, 32'd44100);
    append_data(0, 32'd6, 0);
    push_le(32'h7fff_8000, 4);
    push_le(32'h0001, 2);
    feed_file();
    // Wrong RIFF tag.
    build_header(wpsd_pkg::PCM_TAG, 16'd1, 16'd8, 32'd8000);
    file_bytes[3] ^= 8'h01;
    trim_file(6);
    feed_file();
    // Non-PCM format, then loose bytes while waiting.
    build_header(16'd3, 16'd1, 16'd16, 32'd8000);
    feed_file();
    send_noise(4);
    // Channel count of zero.
    build_header(wpsd_pkg::PCM_TAG, 16'd0, 16'd8, 32'd8000);
    feed_file();
    // Bit depth of 24.
    build_header(wpsd_pkg::PCM_TAG, 16'd2, 16'd24, 32'd8000);
    feed_file();
    // Data size of zero.
    build_header(wpsd_pkg::PCM_TAG, 16'd2, 16'd8, 32'd22050);
    append_data(0, 32'd0, 0);
    feed_file();
    // Data size below one frame: header only, no frames.
    build_header(wpsd_pkg::PCM_TAG, 16'd2, 16'd16, 32'd22050);
    append_data(0, 32'd3, 1);
    feed_file();
    // Restart in the middle of the header.
    build_header(wpsd_pkg::PCM_TAG, 16'd1, 16'd16, 32'd11025);
    trim_file('h10);
    feed_file();
    // No idling on either side across the two long search files.
    calm <= 1'b1;
    // Marker ending one byte past the search window: not found.
    build_header(wpsd_pkg::PCM_TAG, 16'd1, 16'd8, 32'd8000);
    append_data(wpsd_pkg::SEARCH_WINDOW_DEFAULT - 3 - 'h24, 32'd2, 0);
    trim_file(wpsd_pkg::SEARCH_WINDOW_DEFAULT);
    feed_file();
    // Marker whose last byte sits on the final offset of the window: found.
    build_header(wpsd_pkg::PCM_TAG, 16'd1, 16'd8, 32'd8000);
    append_data(wpsd_pkg::SEARCH_WINDOW_DEFAULT - 4 - 'h24, 32'd1, 1);
    feed_file();
    calm <= 1'b0;

    // --- random files: mostly well formed, the rest broken or noise ---
    file_no = 0;
    while (fed_bytes < 850 || file_no < 3) begin
      file_no++;
      pick = $urandom_range(99);
      fmt_code = wpsd_pkg::PCM_TAG;
      chans = 16'($urandom_range(1, 2));
      sample_bits = $urandom_range(1) ? 16'd16 : 16'd8;
      rate = $urandom;
      fb = chans * sample_bits / 8;
      if (pick < 70) begin
        gap = ($urandom_range(19) == 0)
              ? $urandom_range(wpsd_pkg::SEARCH_WINDOW_DEFAULT - 4 - 'h24)
              : $urandom_range(6);
        nfr = $urandom_range(12);
        data_len = nfr * fb + (($urandom_range(3) == 0) ? $urandom_range(3) : 0);
        body = nfr * fb + $urandom_range(3);
        // Now and then claim a huge size and cut the file short.
        if ($urandom_range(15) == 0) begin
          data_len = $urandom;
          body = $urandom_range(20);
        end
        build_header(fmt_code, chans, sample_bits, rate);
        append_data(gap, data_len, body);
        feed_file();
      end else if (pick < 90) begin
        flaw = $urandom_range(5);
        data_len = 2 * fb;
        case (flaw)
          1: fmt_code = 16'($urandom_range(16'hffff));
          2: chans = 16'($urandom_range(16'hffff));
          3: sample_bits = 16'($urandom_range(16'hffff));
          4: data_len = 32'd0;
          default: ;
        endcase
        build_header(fmt_code, chans, sample_bits, rate);
        append_data($urandom_range(4), data_len, 4);
        if (flaw == 0) file_bytes[$urandom_range(3)] ^= 8'h01 << $urandom_range(7);
        if (flaw == 5) trim_file($urandom_range(1, file_bytes.size() - 1));
        feed_file();
      end else begin
        // Loose bytes, then a short garbage file, sometimes with part or all of a real tag.
        send_noise($urandom_range(1, 6));
        file_bytes.delete();
        if ($urandom_range(1)) push_le(wpsd_pkg::RIFF_TAG, $urandom_range(1, 4));
        push_random($urandom_range(1, 8));
        feed_file();
      end
    end

    // Drain: stop idling and wait for every due result before closing the check.
    in_valid <= 1'b0;
    calm <= 1'b1;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    closing <= 1'b1;
    repeat (3) @(posedge clk);
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wpsd_pkg.sv
hdl/wpsd_front.sv
hdl/wpsd_queue.sv
hdl/wpsd_back.sv
hdl/wav_pcm_stream_decoder_top.sv
sim/wav_decode_checker.sv
sim/testbench.sv
